// File: design/dtp_pkg.sv
// Shared constants, result codes, snapshot type and digit helpers for the date text parser.
package dtp_pkg;

    // Field widths.
    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 14;
    localparam int COUNT_W = 5;
    localparam int RUNS_W  = 3;
    localparam int LEAD_W  = 7;
    localparam int TAIL_W  = 8;
    localparam int STAT_W  = 2;

    // Default limit on the characters that count.
    localparam int DTP_MAX_CHARS = 19;

    // Format and range constants.
    localparam logic [COUNT_W-1:0] DIGITS_SHORT = 5'd6;
    localparam logic [COUNT_W-1:0] DIGITS_LONG  = 5'd8;
    localparam logic [COUNT_W-1:0] SEPS_RUNS    = 5'd2;
    localparam logic [COUNT_W-1:0] COUNT_SAT    = 5'd31;
    localparam logic [COUNT_W-1:0] RUN_YEAR_LEN = 5'd4;
    localparam logic [RUNS_W-1:0]  RUNS_DATE    = 3'd3;
    localparam logic [RUNS_W-1:0]  RUNS_SAT     = 3'd4;
    localparam logic [VALUE_W-1:0] YEAR_BASE    = 14'd2000;
    localparam logic [VALUE_W-1:0] MONTH_MAX    = 14'd12;
    localparam logic [VALUE_W-1:0] DAY_MAX      = 14'd31;
    localparam logic [16:0]        RUN_SAT      = 17'd9999;

    // Result codes.
    localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_BAD_FORMAT = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_BAD_MONTH  = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_BAD_DAY    = 2'd3;

    // Everything the format decode needs from the parse state at the end of a string.
    typedef struct packed {
        logic [COUNT_W-1:0] sep_count;
        logic [COUNT_W-1:0] digit_count;
        logic [RUNS_W-1:0]  run_count;
        logic [VALUE_W-1:0] run0_value;
        logic [VALUE_W-1:0] run1_value;
        logic [VALUE_W-1:0] run2_value;
        logic               run0_len4;
        logic               run2_len4;
        logic [TAIL_W-1:0]  run0_tail;
        logic [TAIL_W-1:0]  run2_tail;
        logic [LEAD_W-1:0]  lead_month;
        logic [LEAD_W-1:0]  lead_day;
        logic [VALUE_W-1:0] lead_year;
        logic [TAIL_W-1:0]  year_tail;
    } snapshot_t;

    // Appends one decimal digit to a run value, saturating at 9999.
    function automatic logic [VALUE_W-1:0] acc_digit(input logic [VALUE_W-1:0] value,
                                                     input logic [3:0] digit);
        logic [16:0] sum;
        sum = {3'b000, value} * 17'd10 + {13'd0, digit};
        return (sum > RUN_SAT) ? RUN_SAT[VALUE_W-1:0] : sum[VALUE_W-1:0];
    endfunction

    // Converts the last two digits, held as two BCD nibbles, into a binary value.
    function automatic logic [VALUE_W-1:0] tail_value(input logic [TAIL_W-1:0] tail);
        return VALUE_W'(tail[7:4]) * 14'd10 + VALUE_W'(tail[3:0]);
    endfunction

endpackage

// File: design/date_text_parser.sv
// Date text parser: takes a date string one character per transaction and gives the parsed date.
//
//  Channel | Direction | Handshake          | Payload
//  s_      | input     | s_valid / s_ready  | s_char_code[7:0], s_last
//  m_      | output    | m_valid / m_ready  | m_status[1:0], m_month, m_day, m_year_short,
//          |           |                    | m_year_full (14 bits each)
//
// One character is taken in every cycle while s_ready is high. A character passes the input
// register and then updates the parse counters and digit accumulators; a final character also
// latches a snapshot and clears the parse state, and the format decode then loads the result
// register from that snapshot.
// Reset (aresetn low at a clock edge) empties all three registers and clears the parse state.
// A stall on m_ready holds the result register; the snapshot and input registers keep filling,
// and s_ready falls only once all of them hold a transaction that cannot move on.
module date_text_parser #(
    parameter int MAX_CHARS = dtp_pkg::DTP_MAX_CHARS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [dtp_pkg::CHAR_W-1:0]   s_char_code,
    input  logic                         s_last,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [dtp_pkg::STAT_W-1:0]   m_status,
    output logic [dtp_pkg::VALUE_W-1:0]  m_month,
    output logic [dtp_pkg::VALUE_W-1:0]  m_day,
    output logic [dtp_pkg::VALUE_W-1:0]  m_year_short,
    output logic [dtp_pkg::VALUE_W-1:0]  m_year_full
);

    localparam int CNT_W = $clog2(MAX_CHARS + 1);
    localparam int CW    = dtp_pkg::COUNT_W;
    localparam int VW    = dtp_pkg::VALUE_W;
    localparam int TW    = dtp_pkg::TAIL_W;
    localparam int LW    = dtp_pkg::LEAD_W;
    localparam int RW    = dtp_pkg::RUNS_W;

    // Input register.
    logic                       in_valid_reg;
    logic [dtp_pkg::CHAR_W-1:0] in_char_reg;
    logic                       in_last_reg;

    // Parse state.
    logic [CNT_W-1:0] char_count_reg, char_count_next, upd_char_count;
    logic             ended_reg, ended_next, upd_ended;
    logic             in_run_reg, in_run_next, upd_in_run;
    logic [CW-1:0]    digit_count_reg, digit_count_next, upd_digit_count;
    logic [CW-1:0]    sep_count_reg, sep_count_next, upd_sep_count;
    logic [RW-1:0]    run_count_reg, run_count_next, upd_run_count;
    logic [VW-1:0]    run_value_reg [3];
    logic [VW-1:0]    run_value_next [3];
    logic [VW-1:0]    upd_run_value [3];
    logic [CW-1:0]    run_len_reg [3];
    logic [CW-1:0]    run_len_next [3];
    logic [CW-1:0]    upd_run_len [3];
    logic [TW-1:0]    run_tail_reg [3];
    logic [TW-1:0]    run_tail_next [3];
    logic [TW-1:0]    upd_run_tail [3];
    logic [LW-1:0]    lead_month_reg, lead_month_next, upd_lead_month;
    logic [LW-1:0]    lead_day_reg, lead_day_next, upd_lead_day;
    logic [VW-1:0]    lead_year_reg, lead_year_next, upd_lead_year;
    logic [TW-1:0]    year_tail_reg, year_tail_next, upd_year_tail;

    // Snapshot register.
    logic               snap_valid_reg;
    dtp_pkg::snapshot_t snap_reg, snap_next;

    // Result register.
    logic                       m_valid_reg;
    logic [dtp_pkg::STAT_W-1:0] m_status_reg, m_status_next;
    logic [VW-1:0]              m_month_reg, m_month_next;
    logic [VW-1:0]              m_day_reg, m_day_next;
    logic [VW-1:0]              m_year_short_reg, m_year_short_next;
    logic [VW-1:0]              m_year_full_reg, m_year_full_next;

    // Handshake between the stages.
    logic       out_ready;
    logic       snap_ready;
    logic       in_fire;
    logic       end_fire;
    logic       take_char;
    logic       is_digit;
    logic [3:0] digit;

    assign out_ready  = !m_valid_reg || m_ready;
    assign snap_ready = !snap_valid_reg || out_ready;
    assign in_fire    = in_valid_reg && (!in_last_reg || snap_ready);
    assign end_fire   = in_fire && in_last_reg;
    assign s_ready    = !in_valid_reg || in_fire;

    // The input register takes a new transaction whenever it empties or moves on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_code;
            in_last_reg <= s_last;
        end
    end

    // Character classification. A digit's value is the low nibble of its ASCII code.
    assign take_char = !ended_reg && (char_count_reg < CNT_W'(MAX_CHARS));
    assign is_digit  = in_char_reg inside {[8'h30:8'h39]};
    assign digit     = in_char_reg[3:0];

    // Parse state update for one character, then the snapshot and the clear at the end.
    always_comb begin
        upd_char_count  = char_count_reg;
        upd_ended       = ended_reg;
        upd_in_run      = in_run_reg;
        upd_digit_count = digit_count_reg;
        upd_sep_count   = sep_count_reg;
        upd_run_count   = run_count_reg;
        upd_lead_month  = lead_month_reg;
        upd_lead_day    = lead_day_reg;
        upd_lead_year   = lead_year_reg;
        upd_year_tail   = year_tail_reg;
        for (int i = 0; i < 3; i++) begin
            upd_run_value[i] = run_value_reg[i];
            upd_run_len[i]   = run_len_reg[i];
            upd_run_tail[i]  = run_tail_reg[i];
        end

        if (in_fire && take_char) begin
            if (in_char_reg == '0) begin
                upd_ended = 1'b1;
            end else begin
                upd_char_count = char_count_reg + 1'b1;
                if (is_digit) begin
                    // A digit after a separator, or at the start, opens a new run.
                    if (!in_run_reg) begin
                        if (run_count_reg < dtp_pkg::RUNS_SAT) begin
                            upd_run_count = run_count_reg + 1'b1;
                        end
                        upd_in_run = 1'b1;
                    end
                    for (int i = 0; i < 3; i++) begin
                        if (upd_run_count == RW'(i + 1)) begin
                            upd_run_value[i] = dtp_pkg::acc_digit(run_value_reg[i], digit);
                            if (run_len_reg[i] < dtp_pkg::COUNT_SAT) begin
                                upd_run_len[i] = run_len_reg[i] + 1'b1;
                            end
                            upd_run_tail[i] = {run_tail_reg[i][3:0], digit};
                        end
                    end
                    // Fixed-position fields for the forms without separators.
                    if (digit_count_reg < 5'd2) begin
                        upd_lead_month = lead_month_reg * 7'd10 + {3'b000, digit};
                    end else if (digit_count_reg < 5'd4) begin
                        upd_lead_day = lead_day_reg * 7'd10 + {3'b000, digit};
                    end else if (digit_count_reg < dtp_pkg::DIGITS_LONG) begin
                        upd_lead_year = lead_year_reg * 14'd10 + {10'd0, digit};
                        upd_year_tail = {year_tail_reg[3:0], digit};
                    end
                    if (digit_count_reg < dtp_pkg::COUNT_SAT) begin
                        upd_digit_count = digit_count_reg + 1'b1;
                    end
                end else begin
                    if (sep_count_reg < dtp_pkg::COUNT_SAT) begin
                        upd_sep_count = sep_count_reg + 1'b1;
                    end
                    upd_in_run = 1'b0;
                end
            end
        end

        snap_next.sep_count   = upd_sep_count;
        snap_next.digit_count = upd_digit_count;
        snap_next.run_count   = upd_run_count;
        snap_next.run0_value  = upd_run_value[0];
        snap_next.run1_value  = upd_run_value[1];
        snap_next.run2_value  = upd_run_value[2];
        snap_next.run0_len4   = (upd_run_len[0] == dtp_pkg::RUN_YEAR_LEN);
        snap_next.run2_len4   = (upd_run_len[2] == dtp_pkg::RUN_YEAR_LEN);
        snap_next.run0_tail   = upd_run_tail[0];
        snap_next.run2_tail   = upd_run_tail[2];
        snap_next.lead_month  = upd_lead_month;
        snap_next.lead_day    = upd_lead_day;
        snap_next.lead_year   = upd_lead_year;
        snap_next.year_tail   = upd_year_tail;

        // A final character leaves the parse state clear for the next string.
        if (end_fire) begin
            char_count_next  = '0;
            ended_next       = 1'b0;
            in_run_next      = 1'b0;
            digit_count_next = '0;
            sep_count_next   = '0;
            run_count_next   = '0;
            lead_month_next  = '0;
            lead_day_next    = '0;
            lead_year_next   = '0;
            year_tail_next   = '0;
            for (int i = 0; i < 3; i++) begin
                run_value_next[i] = '0;
                run_len_next[i]   = '0;
                run_tail_next[i]  = '0;
            end
        end else begin
            char_count_next  = upd_char_count;
            ended_next       = upd_ended;
            in_run_next      = upd_in_run;
            digit_count_next = upd_digit_count;
            sep_count_next   = upd_sep_count;
            run_count_next   = upd_run_count;
            lead_month_next  = upd_lead_month;
            lead_day_next    = upd_lead_day;
            lead_year_next   = upd_lead_year;
            year_tail_next   = upd_year_tail;
            for (int i = 0; i < 3; i++) begin
                run_value_next[i] = upd_run_value[i];
                run_len_next[i]   = upd_run_len[i];
                run_tail_next[i]  = upd_run_tail[i];
            end
        end
    end

    // Parse state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_count_reg  <= '0;
            ended_reg       <= 1'b0;
            in_run_reg      <= 1'b0;
            digit_count_reg <= '0;
            sep_count_reg   <= '0;
            run_count_reg   <= '0;
            lead_month_reg  <= '0;
            lead_day_reg    <= '0;
            lead_year_reg   <= '0;
            year_tail_reg   <= '0;
            for (int i = 0; i < 3; i++) begin
                run_value_reg[i] <= '0;
                run_len_reg[i]   <= '0;
                run_tail_reg[i]  <= '0;
            end
        end else begin
            char_count_reg  <= char_count_next;
            ended_reg       <= ended_next;
            in_run_reg      <= in_run_next;
            digit_count_reg <= digit_count_next;
            sep_count_reg   <= sep_count_next;
            run_count_reg   <= run_count_next;
            lead_month_reg  <= lead_month_next;
            lead_day_reg    <= lead_day_next;
            lead_year_reg   <= lead_year_next;
            year_tail_reg   <= year_tail_next;
            for (int i = 0; i < 3; i++) begin
                run_value_reg[i] <= run_value_next[i];
                run_len_reg[i]   <= run_len_next[i];
                run_tail_reg[i]  <= run_tail_next[i];
            end
        end
    end

    // Snapshot register: loaded by a final character.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (snap_ready) begin
            snap_valid_reg <= end_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (end_fire) begin
            snap_reg <= snap_next;
        end
    end

    // Format decode and range checks.
    always_comb begin
        logic fmt_short;
        logic fmt_long;
        logic fmt_runs;
        fmt_short = (snap_reg.sep_count == '0) && (snap_reg.digit_count == dtp_pkg::DIGITS_SHORT);
        fmt_long  = (snap_reg.sep_count == '0) && (snap_reg.digit_count == dtp_pkg::DIGITS_LONG);
        fmt_runs  = (snap_reg.sep_count == dtp_pkg::SEPS_RUNS)
                    && (snap_reg.run_count == dtp_pkg::RUNS_DATE);

        m_month_next      = '0;
        m_day_next        = '0;
        m_year_short_next = '0;
        m_year_full_next  = '0;

        if (fmt_short) begin
            m_month_next      = VW'(snap_reg.lead_month);
            m_day_next        = VW'(snap_reg.lead_day);
            m_year_short_next = snap_reg.lead_year;
            m_year_full_next  = snap_reg.lead_year + dtp_pkg::YEAR_BASE;
        end else if (fmt_long) begin
            m_month_next      = VW'(snap_reg.lead_month);
            m_day_next        = VW'(snap_reg.lead_day);
            m_year_full_next  = snap_reg.lead_year;
            m_year_short_next = dtp_pkg::tail_value(snap_reg.year_tail);
        end else if (fmt_runs) begin
            if (snap_reg.run0_len4) begin
                // Year first.
                m_year_full_next  = snap_reg.run0_value;
                m_year_short_next = dtp_pkg::tail_value(snap_reg.run0_tail);
                m_month_next      = snap_reg.run1_value;
                m_day_next        = snap_reg.run2_value;
            end else begin
                m_month_next = snap_reg.run0_value;
                m_day_next   = snap_reg.run1_value;
                if (snap_reg.run2_len4) begin
                    m_year_full_next  = snap_reg.run2_value;
                    m_year_short_next = dtp_pkg::tail_value(snap_reg.run2_tail);
                end else begin
                    m_year_short_next = snap_reg.run2_value;
                    m_year_full_next  = snap_reg.run2_value + dtp_pkg::YEAR_BASE;
                end
            end
        end

        if (!(fmt_short || fmt_long || fmt_runs)) begin
            m_status_next = dtp_pkg::STATUS_BAD_FORMAT;
        end else if (m_month_next == '0 || m_month_next > dtp_pkg::MONTH_MAX) begin
            m_status_next = dtp_pkg::STATUS_BAD_MONTH;
        end else if (m_day_next == '0 || m_day_next > dtp_pkg::DAY_MAX) begin
            m_status_next = dtp_pkg::STATUS_BAD_DAY;
        end else begin
            m_status_next = dtp_pkg::STATUS_OK;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= snap_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && snap_valid_reg) begin
            m_status_reg     <= m_status_next;
            m_month_reg      <= m_month_next;
            m_day_reg        <= m_day_next;
            m_year_short_reg <= m_year_short_next;
            m_year_full_reg  <= m_year_full_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_month      = m_month_reg;
    assign m_day        = m_day_reg;
    assign m_year_short = m_year_short_reg;
    assign m_year_full  = m_year_full_reg;

    // A result only appears after a snapshot was waiting for it.
    a_result_from_snapshot: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(snap_valid_reg))
        else $error("result raised without a pending snapshot");

    // The parse state is clear after the final character of a string.
    a_state_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        end_fire |=> (char_count_reg == '0 && run_count_reg == '0 && !ended_reg
                      && digit_count_reg == '0 && sep_count_reg == '0))
        else $error("parse state not cleared after the final character");

    // A bad format carries all-zero date fields.
    a_bad_format_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == dtp_pkg::STATUS_BAD_FORMAT)
        |-> (m_month_reg == '0 && m_day_reg == '0
             && m_year_short_reg == '0 && m_year_full_reg == '0))
        else $error("bad format result with non-zero fields");

    // A good status means month and day are in range.
    a_ok_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == dtp_pkg::STATUS_OK)
        |-> (m_month_reg != '0 && m_month_reg <= dtp_pkg::MONTH_MAX
             && m_day_reg != '0 && m_day_reg <= dtp_pkg::DAY_MAX))
        else $error("good status with month or day out of range");

    // The character counter never passes its limit.
    a_char_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        char_count_reg <= CNT_W'(MAX_CHARS))
        else $error("character counter beyond its limit");

endmodule
